FILE: rtl/gpio_fssc_pkg.sv
// Shared constants, word map and item types for the GPIO function-select/set/clear block.
package gpio_fssc_pkg;

  // Pin count and field widths
  localparam int NumPins     = 54;
  localparam int WordW       = 6;
  localparam int DataW       = 32;
  localparam int FselW       = 3;
  localparam int BankW       = 64;
  localparam int PinsPerFsel = 10;
  localparam int FselWords   = 6;
  localparam int FselIdxW    = $clog2(FselWords);

  // Access kinds
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Word map
  localparam logic [WordW-1:0] WordSet0 = WordW'(7);
  localparam logic [WordW-1:0] WordSet1 = WordW'(8);
  localparam logic [WordW-1:0] WordClr0 = WordW'(10);
  localparam logic [WordW-1:0] WordClr1 = WordW'(11);
  localparam logic [WordW-1:0] WordLev0 = WordW'(13);
  localparam logic [WordW-1:0] WordLev1 = WordW'(14);

  // Function code that drives the pin
  localparam logic [FselW-1:0] FselOutput = FselW'(1);

  // One bus access with the pin levels sampled alongside it
  typedef struct packed {
    logic                opcode;
    logic [WordW-1:0]    word_index;
    logic [DataW-1:0]    write_data;
    logic [NumPins-1:0]  pin_in;
  } access_t;

  // One result item
  typedef struct packed {
    logic [DataW-1:0]    read_data;
    logic [NumPins-1:0]  pin_out;
    logic [NumPins-1:0]  pin_drive;
  } result_t;

endpackage

FILE: rtl/gpio_fssc_if.sv
// Valid/ready channel interfaces for bus access items and result items.
interface gpio_fssc_in_if import gpio_fssc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [WordW-1:0]   word_index;
  logic [DataW-1:0]   write_data;
  logic [NumPins-1:0] pin_in;

  modport source (output valid, opcode, word_index, write_data, pin_in, input ready);
  modport sink   (input valid, opcode, word_index, write_data, pin_in, output ready);
endinterface

interface gpio_fssc_out_if import gpio_fssc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DataW-1:0]   read_data;
  logic [NumPins-1:0] pin_out;
  logic [NumPins-1:0] pin_drive;

  modport source (output valid, read_data, pin_out, pin_drive, input ready);
  modport sink   (input valid, read_data, pin_out, pin_drive, output ready);
endinterface

FILE: rtl/gpio_fssc_regs.sv
// Register file: function selects, output latch, word read mux and next-state logic.
module gpio_fssc_regs import gpio_fssc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    acc_valid_i,
  input  access_t acc_i,
  output result_t res_o
);

  logic [FselW-1:0]   fsel_q [NumPins];
  logic [FselW-1:0]   fsel_d [NumPins];
  logic [NumPins-1:0] latch_q;
  logic [NumPins-1:0] latch_d;
  logic [NumPins-1:0] drive_now;
  logic [NumPins-1:0] drive_next;
  logic [NumPins-1:0] level;
  logic [BankW-1:0]   level_ext;
  logic [BankW-1:0]   bank_mask;
  logic [DataW-1:0]   fsel_word [FselWords];
  logic [DataW-1:0]   rd_data;
  logic               is_write;
  logic               wr_fsel;
  logic               wr_set;
  logic               wr_clr;

  // Decode of the access
  assign is_write = acc_valid_i && (acc_i.opcode == OpWrite);
  assign wr_fsel  = is_write && (acc_i.word_index < WordW'(FselWords));
  assign wr_set   = is_write && ((acc_i.word_index == WordSet0) ||
                                 (acc_i.word_index == WordSet1));
  assign wr_clr   = is_write && ((acc_i.word_index == WordClr0) ||
                                 (acc_i.word_index == WordClr1));

  // Per-pin function select update and drive enables
  for (genvar p = 0; p < NumPins; p++) begin : g_pin
    localparam int FselWord = p / PinsPerFsel;
    localparam int FselLsb  = (p % PinsPerFsel) * FselW;
    if (FselWord < FselWords) begin : g_fsel
      assign fsel_d[p] = (wr_fsel && (acc_i.word_index == WordW'(FselWord)))
                       ? acc_i.write_data[FselLsb +: FselW] : fsel_q[p];
    end else begin : g_nofsel
      // pins past the last select word stay in input mode
      assign fsel_d[p] = fsel_q[p];
    end
    assign drive_now[p]  = (fsel_q[p] == FselOutput);
    assign drive_next[p] = (fsel_d[p] == FselOutput);
  end

  // Set/clear mask widened to the addressed bank
  always_comb begin
    if ((acc_i.word_index == WordSet1) || (acc_i.word_index == WordClr1)) begin
      bank_mask = {acc_i.write_data, {(BankW-DataW){1'b0}}};
    end else begin
      bank_mask = {{(BankW-DataW){1'b0}}, acc_i.write_data};
    end
  end

  // Output latch next value
  always_comb begin
    latch_d = latch_q;
    if (wr_set) begin
      latch_d = latch_q | bank_mask[NumPins-1:0];
    end else if (wr_clr) begin
      latch_d = latch_q & ~bank_mask[NumPins-1:0];
    end
  end

  // Function select words as seen on a read
  always_comb begin
    for (int w = 0; w < FselWords; w++) begin
      fsel_word[w] = '0;
      for (int i = 0; i < PinsPerFsel; i++) begin
        if (w * PinsPerFsel + i < NumPins) begin
          fsel_word[w][i*FselW +: FselW] = fsel_q[w * PinsPerFsel + i];
        end
      end
    end
  end

  // Pin level: latch for output pins, external level otherwise
  assign level     = (latch_q & drive_now) | (acc_i.pin_in & ~drive_now);
  assign level_ext = BankW'(level);

  // Read mux
  always_comb begin
    case (acc_i.word_index) inside
      [WordW'(0):WordW'(FselWords-1)]: rd_data = fsel_word[acc_i.word_index[FselIdxW-1:0]];
      WordLev0:    rd_data = level_ext[DataW-1:0];
      WordLev1:    rd_data = level_ext[BankW-1:DataW];
      default:     rd_data = '0;
    endcase
    if (acc_i.opcode == OpWrite) begin
      rd_data = '0;
    end
  end

  assign res_o.read_data = rd_data;
  assign res_o.pin_out   = latch_d;
  assign res_o.pin_drive = drive_next;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPins; p++) begin
        fsel_q[p] <= '0;
      end
      latch_q <= '0;
    end else begin
      fsel_q  <= fsel_d;
      latch_q <= latch_d;
    end
  end

endmodule

FILE: rtl/gpio_function_select_set_clear_top.sv
// Top level of the GPIO function-select/set/clear register block.
// Each input item is one register access (read or write of a 32-bit word)
// together with the current pin levels; it yields exactly one result item
// with the read data (0 for writes and unmapped words), the output latch
// and the drive enables as they stand after the access. An item is decoded,
// applied to the register file and captured in the result register in the
// cycle it is accepted, so the block takes one item per clock unless stalled;
// the result appears in the next cycle. Input ready is low only while the
// result register is full and its item is not being taken. Words 0-5 select
// pin functions, 7/8 set and 10/11 clear latch bits, 13/14 read pin levels.
module gpio_function_select_set_clear_top import gpio_fssc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  gpio_fssc_in_if.sink    in_i,
  gpio_fssc_out_if.source out_o
);

  access_t acc;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    in_accept;

  // Accept whenever the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign acc.opcode     = in_i.opcode;
  assign acc.word_index = in_i.word_index;
  assign acc.write_data = in_i.write_data;
  assign acc.pin_in     = in_i.pin_in;

  gpio_fssc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (in_accept),
    .acc_i       (acc),
    .res_o       (res)
  );

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = res_q.read_data;
  assign out_o.pin_out   = res_q.pin_out;
  assign out_o.pin_drive = res_q.pin_drive;

endmodule
